FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: design/easra_pkg.sv
// Package: shared types and codes of the shelf rectangle allocator.
package easra_pkg;
   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_RESET = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_PAGE  = 2'd1;
   localparam logic [1:0] ST_LIST_FULL = 2'd2;
   localparam logic [1:0] ST_BAD_PAGE = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] width;
      logic [10:0] height;
      logic [3:0]  page;
      logic [10:0] pos_x;
      logic [10:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  out_page;
      logic [10:0] out_x;
      logic [10:0] out_y;
      logic        reused;
   } rsp_type;
endpackage

FILE: design/easra_if.sv
// Interfaces: valid/ready channels for request and response beats.
interface easra_req_if (input logic clock);
   logic                 valid;
   logic                 ready;
   easra_pkg::req_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface easra_rsp_if (input logic clock);
   logic                 valid;
   logic                 ready;
   easra_pkg::rsp_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/even_aligned_shelf_rect_allocator_core.sv
// Top level: shelf rectangle allocator with per-page free lists.
// One request beat gives one response beat. A free beat passes through
// S_FREE and S_OUT; a reset beat goes straight to S_OUT. An allocation
// scans the free-list memory entry by entry, because every read is
// registered before its compare: S_SCAN_RD reads, S_SCAN_CHK compares.
// It then walks the page cursors, which live in a second memory, page by
// page through S_SHELF_RD and S_SHELF_CHK. If no open page fits, S_NEWPAGE
// opens a new page, and S_OUT posts the response. A hit in the free list
// moves the last entry into the freed slot through S_MOVE_RD and S_MOVE_WR.
// The free-list memory has no reset: only entries below a page's fill count
// are ever used. Fill counts are flip-flops, and the cursors are qualified
// by per-page valid bits: a reset beat clears the counts and the valid bits
// at once, so no clearing pass is needed. One request is worked at a time;
// the response waits in an output register, and the next request is taken
// as soon as that register is free.
module even_aligned_shelf_rect_allocator_core #(
   parameter int ATLAS_SIZE = 2048,
   parameter int MAX_PAGES  = 8,
   parameter int FREE_SLOTS = 64
) (
   input logic clock,
   input logic reset,
   easra_req_if.sink   req,
   easra_rsp_if.source rsp
);
   localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int SW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CW = $clog2(FREE_SLOTS + 1);
   localparam int OW = $clog2(MAX_PAGES + 1);
   localparam int DW = ((ATLAS_SIZE > 2048) ? $clog2(ATLAS_SIZE) : 11) + 2;
   localparam int ROWS = MAX_PAGES * (2 ** SW);
   localparam logic [DW-1:0] ATLAS = DW'(ATLAS_SIZE);

   typedef enum logic [3:0] {
      S_IDLE, S_FREE, S_SCAN_RD, S_SCAN_CHK, S_MOVE_RD, S_MOVE_WR,
      S_SHELF_RD, S_SHELF_CHK, S_NEWPAGE, S_OUT
   } state_type;

   typedef struct packed {
      logic [10:0] x;
      logic [10:0] y;
      logic [11:0] w;
      logic [11:0] h;
   } rect_type;

   typedef struct packed {
      logic [DW-1:0] x;
      logic [DW-1:0] y;
      logic [DW-1:0] rh;
   } shelf_type;

   // Free rectangles, one row of 2**SW slots per page.
   rect_type  free_mem [ROWS];
   // Shelf cursors per page; an invalid page reads as zero.
   shelf_type shelf_mem [MAX_PAGES];

   state_type           state_ff;
   easra_pkg::req_type  cur_ff;
   easra_pkg::rsp_type  rsp_ff;
   logic                rsp_valid_ff;
   logic [OW-1:0]       pages_open_ff;
   logic [CW-1:0]       count_ff [MAX_PAGES];
   logic [MAX_PAGES-1:0] shelf_ok_ff;
   logic [PW-1:0]       pg_ff;
   logic [CW-1:0]       ent_ff;
   logic [SW-1:0]       hit_ff;
   logic [11:0]         sw_ff, sh_ff;
   rect_type            rd_ff, hitr_ff;
   shelf_type           srd_ff;

   logic [11:0] sw_in, sh_in;
   logic [CW-1:0] n_cur;
   logic [PW-1:0] last_pg;
   logic          ent_last, pg_last;
   shelf_type     sh_cur, sh_w;
   logic [DW-1:0] sw_d, sh_d;

   function automatic logic [11:0] slot_dim(input logic [10:0] v);
      logic [11:0] t;
      t = {1'b0, v} + 12'd1;
      return {t[11:1], 1'b0} + 12'd2;
   endfunction

   assign sw_in = slot_dim(cur_ff.width);
   assign sh_in = slot_dim(cur_ff.height);
   assign sw_d  = DW'(sw_ff);
   assign sh_d  = DW'(sh_ff);
   assign n_cur = count_ff[pg_ff];
   assign last_pg = PW'(pages_open_ff - OW'(1));
   assign pg_last = (OW'(pg_ff) + OW'(1) >= pages_open_ff);
   assign ent_last = (ent_ff + CW'(1) >= n_cur);
   assign sh_cur = shelf_ok_ff[pg_ff] ? srd_ff : '0;

   // Apply the row wrap before the height test.
   always_comb begin
      sh_w = sh_cur;
      if (sh_cur.x + sw_d > ATLAS) begin
         sh_w.x  = '0;
         sh_w.y  = sh_cur.y + sh_cur.rh;
         sh_w.rh = '0;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // Memory ports: one read and one write per cycle each.
   always_ff @(posedge clock) begin
      rd_ff  <= free_mem[{pg_ff, SW'(ent_ff)}];
      srd_ff <= shelf_mem[pg_ff];
      if (state_ff == S_FREE && OW'(cur_ff.page) < pages_open_ff &&
          {28'd0, cur_ff.page} < MAX_PAGES && n_cur < CW'(FREE_SLOTS))
         free_mem[{pg_ff, SW'(n_cur)}] <= '{cur_ff.pos_x, cur_ff.pos_y, sw_in, sh_in};
      if (state_ff == S_MOVE_WR)
         free_mem[{pg_ff, hit_ff}] <= rd_ff;
      if (state_ff == S_SHELF_CHK && sh_w.y + sh_d <= ATLAS)
         shelf_mem[pg_ff] <= '{sh_w.x + sw_d, sh_w.y,
                               (sh_d > sh_w.rh) ? sh_d : sh_w.rh};
      else if (state_ff == S_SHELF_CHK)
         shelf_mem[pg_ff] <= sh_w;
      else if (state_ff == S_NEWPAGE && pages_open_ff < OW'(MAX_PAGES))
         shelf_mem[PW'(pages_open_ff)] <= '{sw_d, '0, sh_d};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         pages_open_ff <= '0;
         shelf_ok_ff   <= '0;
         for (int i = 0; i < MAX_PAGES; i++) count_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req.valid && req.ready) begin
                  cur_ff <= req.data;
                  ent_ff <= '0;
                  rsp_ff <= '0;
                  case (req.data.mode)
                     easra_pkg::MODE_ALLOC: begin
                        pg_ff    <= '0;
                        state_ff <= S_SCAN_RD;
                     end
                     easra_pkg::MODE_FREE: begin
                        pg_ff    <= PW'(req.data.page);
                        state_ff <= S_FREE;
                     end
                     easra_pkg::MODE_RESET: begin
                        shelf_ok_ff <= '0;
                        for (int i = 0; i < MAX_PAGES; i++) count_ff[i] <= '0;
                        state_ff <= S_OUT;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_FREE: begin
               // The memory write happens in the port block.
               if (!(OW'(cur_ff.page) < pages_open_ff) ||
                   !({28'd0, cur_ff.page} < MAX_PAGES))
                  rsp_ff.status <= easra_pkg::ST_BAD_PAGE;
               else if (n_cur >= CW'(FREE_SLOTS))
                  rsp_ff.status <= easra_pkg::ST_LIST_FULL;
               else
                  count_ff[pg_ff] <= n_cur + CW'(1);
               state_ff <= S_OUT;
            end
            S_SCAN_RD: begin
               sw_ff <= sw_in;
               sh_ff <= sh_in;
               if (pages_open_ff == '0) begin
                  pg_ff    <= '0;
                  state_ff <= S_NEWPAGE;
               end else if (n_cur == '0) begin
                  // Empty list: skip to next page or to the shelf walk.
                  if (pg_last) begin
                     pg_ff    <= '0;
                     state_ff <= S_SHELF_RD;
                  end else pg_ff <= pg_ff + PW'(1);
               end else state_ff <= S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
               if (rd_ff.w >= sw_ff && rd_ff.h >= sh_ff) begin
                  hitr_ff  <= rd_ff;
                  hit_ff   <= SW'(ent_ff);
                  ent_ff   <= n_cur - CW'(1);
                  state_ff <= S_MOVE_RD;
               end else if (!ent_last) begin
                  ent_ff   <= ent_ff + CW'(1);
                  state_ff <= S_SCAN_RD;
               end else begin
                  ent_ff <= '0;
                  if (pg_last) begin
                     pg_ff    <= '0;
                     state_ff <= S_SHELF_RD;
                  end else begin
                     pg_ff    <= pg_ff + PW'(1);
                     state_ff <= S_SCAN_RD;
                  end
               end
            end
            S_MOVE_RD: state_ff <= S_MOVE_WR;
            S_MOVE_WR: begin
               // Replace the hit with the last entry of the list.
               count_ff[pg_ff] <= n_cur - CW'(1);
               rsp_ff <= '{easra_pkg::ST_OK, 3'(pg_ff), hitr_ff.x, hitr_ff.y, 1'b1};
               state_ff <= S_OUT;
            end
            S_SHELF_RD: state_ff <= S_SHELF_CHK;
            S_SHELF_CHK: begin
               shelf_ok_ff[pg_ff] <= 1'b1;
               if (sh_w.y + sh_d <= ATLAS) begin
                  rsp_ff <= '{easra_pkg::ST_OK, 3'(pg_ff), 11'(sh_w.x), 11'(sh_w.y),
                              1'b0};
                  state_ff <= S_OUT;
               end else if (pg_ff == last_pg) state_ff <= S_NEWPAGE;
               else begin
                  pg_ff    <= pg_ff + PW'(1);
                  state_ff <= S_SHELF_RD;
               end
            end
            S_NEWPAGE: begin
               if (pages_open_ff >= OW'(MAX_PAGES))
                  rsp_ff.status <= easra_pkg::ST_NO_PAGE;
               else begin
                  shelf_ok_ff[PW'(pages_open_ff)] <= 1'b1;
                  count_ff[PW'(pages_open_ff)]    <= '0;
                  rsp_ff.out_page <= 3'(pages_open_ff);
                  pages_open_ff   <= pages_open_ff + OW'(1);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: design/easra_checker.sv
// Checker: port-level properties of the allocator, bound to the top level.
`include "assert_macros.svh"
module easra_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input easra_pkg::rsp_type rsp_data
);
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response beat dropped or changed while stalled")
   `CHK_IMPLY(a_no_take_busy, clock, reset, rsp_valid, !req_ready, "request taken while a response waits")
   `CHK_IMPLY(a_fail_zero, clock, reset, rsp_valid && rsp_data.status != easra_pkg::ST_OK, !rsp_data.reused && rsp_data.out_x == '0 && rsp_data.out_y == '0, "failed beat carries a placement")
   `CHK_NEXT(a_one_rsp, clock, reset, rsp_valid && rsp_ready, !rsp_valid, "response repeated")
endmodule

bind even_aligned_shelf_rect_allocator_core easra_checker u_easra_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

FILE: verif/easra_tb_pkg.sv
// Shared constants for the shelf rectangle allocator testbench.
package easra_tb_pkg;
   localparam int ATLAS = 2048;
   localparam int PAGES = 8;
   localparam int SLOTS = 64;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
endpackage

FILE: verif/tb_even_aligned_shelf_rect_allocator_core.sv
// Testbench for the shelf rectangle allocator: directed and random beats against a predictor.
module tb_even_aligned_shelf_rect_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      int x;
      int y;
      int w;
      int h;
   } spare_rect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   easra_req_if req_ch (clock);
   easra_rsp_if rsp_ch (clock);

   even_aligned_shelf_rect_allocator_core dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   // Predictor state: one cursor and one free list per page.
   int        open_pages;
   int        cur_x [easra_tb_pkg::PAGES];
   int        cur_y [easra_tb_pkg::PAGES];
   int        row_h [easra_tb_pkg::PAGES];
   int        spare_cnt [easra_tb_pkg::PAGES];
   spare_rect_type spares [easra_tb_pkg::PAGES][easra_tb_pkg::SLOTS];

   easra_pkg::rsp_type pending_rsp[$];
   int        errors = 0;
   int        cycles = 0;
   int        sent = 0;
   int        checked = 0;
   bit        calm = 1'b0;     // no idling on either side
   int        hold_off = 0;    // receiver long stall, counted in cycles

   function automatic int slot_of(logic [10:0] v);
      return ((int'(v) + 1) & ~1) + 2;
   endfunction

   // Work out the response of one beat and advance the predictor.
   function automatic easra_pkg::rsp_type place_rect(easra_pkg::req_type r);
      easra_pkg::rsp_type o;
      int sw, sh, n;
      o = '0;
      case (r.mode)
         easra_pkg::MODE_ALLOC: begin
            sw = slot_of(r.width);
            sh = slot_of(r.height);
            // First fit among freed rectangles, pages then entries.
            for (int i = 0; i < open_pages; i++) begin
               n = spare_cnt[i];
               for (int j = 0; j < n; j++) begin
                  if (spares[i][j].w >= sw && spares[i][j].h >= sh) begin
                     o.out_page = i[2:0];
                     o.out_x = spares[i][j].x[10:0];
                     o.out_y = spares[i][j].y[10:0];
                     o.reused = 1'b1;
                     spares[i][j] = spares[i][n-1];
                     spare_cnt[i] = n - 1;
                     return o;
                  end
               end
            end
            // Shelf cursors; a row wrap sticks even when the page then fails.
            for (int i = 0; i < open_pages; i++) begin
               if (cur_x[i] + sw > easra_tb_pkg::ATLAS) begin
                  cur_x[i] = 0;
                  cur_y[i] += row_h[i];
                  row_h[i] = 0;
               end
               if (cur_y[i] + sh <= easra_tb_pkg::ATLAS) begin
                  o.out_page = i[2:0];
                  o.out_x = cur_x[i][10:0];
                  o.out_y = cur_y[i][10:0];
                  cur_x[i] += sw;
                  if (sh > row_h[i]) row_h[i] = sh;
                  return o;
               end
            end
            if (open_pages >= easra_tb_pkg::PAGES) begin
               o.status = easra_pkg::ST_NO_PAGE;
               return o;
            end
            cur_x[open_pages] = sw;
            cur_y[open_pages] = 0;
            row_h[open_pages] = sh;
            spare_cnt[open_pages] = 0;
            o.out_page = open_pages[2:0];
            open_pages++;
         end
         easra_pkg::MODE_FREE: begin
            if (int'(r.page) >= open_pages) begin
               o.status = easra_pkg::ST_BAD_PAGE;
            end else if (spare_cnt[r.page] >= easra_tb_pkg::SLOTS) begin
               o.status = easra_pkg::ST_LIST_FULL;
            end else begin
               n = spare_cnt[r.page];
               spares[r.page][n].x = r.pos_x;
               spares[r.page][n].y = r.pos_y;
               spares[r.page][n].w = slot_of(r.width);
               spares[r.page][n].h = slot_of(r.height);
               spare_cnt[r.page] = n + 1;
            end
         end
         easra_pkg::MODE_RESET: begin
            for (int i = 0; i < easra_tb_pkg::PAGES; i++) begin
               cur_x[i] = 0;
               cur_y[i] = 0;
               row_h[i] = 0;
               spare_cnt[i] = 0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      open_pages = 0;
      for (int i = 0; i < easra_tb_pkg::PAGES; i++) begin
         cur_x[i] = 0;
         cur_y[i] = 0;
         row_h[i] = 0;
         spare_cnt[i] = 0;
      end
   end

   // Drive one request beat, with a random gap ahead of it unless calm.
   // Valid stays high after a beat; drop it only when a gap or a pause follows.
   task automatic send_beat(easra_pkg::req_type r);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      // Beat taken at this edge: predict now, before the next beat.
      pending_rsp.push_back(place_rect(r));
      sent++;
   endtask

   task automatic drain_all();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic easra_pkg::req_type mk(logic [1:0] m, int w, int h, int pg,
                                             int x, int y);
      easra_pkg::req_type r;
      r.mode = m;
      r.width = w[10:0];
      r.height = h[10:0];
      r.page = pg[3:0];
      r.pos_x = x[10:0];
      r.pos_y = y[10:0];
      return r;
   endfunction

   // Random beat, biased toward small allocations and valid frees.
   function automatic easra_pkg::req_type rand_beat();
      int k, w, h;
      k = $urandom_range(0, 99);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2046) : $urandom_range(0, 300);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2046) : $urandom_range(0, 300);
      if (k < 55) return mk(easra_pkg::MODE_ALLOC, w, h, $urandom_range(0, 15), 0, 0);
      if (k < 93) return mk(easra_pkg::MODE_FREE, w, h,
                            (k < 88) ? $urandom_range(0, 7) : $urandom_range(0, 15),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
      if (k < 96) return mk(easra_pkg::MODE_RESET, w, h, $urandom_range(0, 15),
                            $urandom_range(0, 2047), $urandom_range(0, 2047));
      return mk(easra_tb_pkg::MODE_UNUSED, w, h, $urandom_range(0, 15),
                $urandom_range(0, 2047), $urandom_range(0, 2047));
   endfunction

   task automatic test_extremes();
      send_beat(mk(easra_pkg::MODE_FREE, 4, 4, 0, 0, 0));          // unknown page, none open
      send_beat(mk(easra_pkg::MODE_ALLOC, 0, 0, 0, 0, 0));         // opens page 0
      send_beat(mk(easra_pkg::MODE_ALLOC, 2046, 2046, 0, 0, 0));   // too big for page 0 (its row wraps), opens page 1
      send_beat(mk(easra_pkg::MODE_ALLOC, 2046, 10, 0, 0, 0));     // fills a full row on page 0
      send_beat(mk(easra_pkg::MODE_ALLOC, 1, 1, 0, 0, 0));
      send_beat(mk(easra_pkg::MODE_FREE, 2046, 2046, 0, 2047, 2047));
      send_beat(mk(easra_pkg::MODE_FREE, 3, 5, 1, 100, 200));
      send_beat(mk(easra_pkg::MODE_ALLOC, 3, 5, 0, 0, 0));         // reuse, first fit
      send_beat(mk(easra_pkg::MODE_FREE, 0, 0, 15, 0, 0));         // bad page
      send_beat(mk(easra_tb_pkg::MODE_UNUSED, 2046, 2046, 15, 2047, 2047));  // unused mode
      send_beat(mk(easra_pkg::MODE_RESET, 0, 0, 0, 0, 0));
      send_beat(mk(easra_pkg::MODE_ALLOC, 7, 9, 0, 0, 0));
   endtask

   task automatic test_page_table_full();
      // Large slots use up all pages, then the remaining allocations fail.
      for (int i = 0; i < 12; i++)
         send_beat(mk(easra_pkg::MODE_ALLOC, 2000, 2000, 0, 0, 0));
   endtask

   task automatic test_list_full();
      for (int i = 0; i < easra_tb_pkg::SLOTS + 2; i++)
         send_beat(mk(easra_pkg::MODE_FREE, 2046, 2046, 1, i, i));
      send_beat(mk(easra_pkg::MODE_ALLOC, 2, 2, 0, 0, 0));
      send_beat(mk(easra_pkg::MODE_RESET, 0, 0, 0, 0, 0));
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      for (int i = 0; i < 10; i++) send_beat(rand_beat());
      drain_all();   // sender pauses until all responses are back
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count - 80) calm = 1'b1;
         send_beat(rand_beat());
      end
   endtask

   // Receiver: random stall bursts, one long hold-off on request.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 11);
            rsp_ch.ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      easra_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected, got %p", $time, rsp_ch.data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            checked++;
            if (want.status !== rsp_ch.data.status || want.out_page !== rsp_ch.data.out_page ||
                want.out_x !== rsp_ch.data.out_x || want.out_y !== rsp_ch.data.out_y ||
                want.reused !== rsp_ch.data.reused) begin
               $display("%0t: mismatch expected %p actual %p", $time, want, rsp_ch.data);
               errors++;
            end
         end
      end
   end

   // Watchdog: fails the run if it does not finish in time, allowing for stalls.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_page_table_full();
      test_list_full();
      test_backpressure();
      test_random(480);
      drain_all();
      repeat (600) @(posedge clock);
      $display("Covered %0d beats, %0d responses checked: allocation, reuse, frees,",
               sent, checked);
      $display("page and list overflow, bad pages, resets and stalls on both sides.");
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+design
design/easra_pkg.sv
design/easra_if.sv
design/even_aligned_shelf_rect_allocator_core.sv
design/easra_checker.sv
verif/easra_tb_pkg.sv
verif/tb_even_aligned_shelf_rect_allocator_core.sv
